// File: hdl/sas_pkg.sv
// Shared types and constants for the sprite animation sequencer.
package sas_pkg;

    localparam int OPCODE_W   = 3;
    localparam int ANIM_ID_W  = 4;
    localparam int SLOT_W     = 4;
    localparam int FIELD_W    = 16;
    localparam int SPRITE_W   = 16;
    localparam int TOTAL_W    = 5;

    typedef enum logic [OPCODE_W-1:0] {
        OP_TICK        = 3'd0,
        OP_PLAY        = 3'd1,
        OP_PLAY_SYNCED = 3'd2,
        OP_WRITE_FRAME = 3'd3,
        OP_DEFINE_ANIM = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MOD,
        ST_LOOKUP,
        ST_RESP
    } state_t;

endpackage

// File: hdl/sprite_animation_sequencer_core.sv
// Sprite animation sequencer: command decode, play state and result register.
// A request passes through the execute, lookup and response states before the
// result is registered; play-synced with a nonzero frame count also waits in the remainder state.
// A new request is taken only in the idle state, once the last result has been loaded,
// with the frame memory read before and after the update (read, modify, read back the new frame).
// Reset: asynchronous, clears play state and animation valid bits at once;
// frame entries stay undefined until written.
module sprite_animation_sequencer_core #(
    parameter int NUM_ANIMS     = 16,
    parameter int MAX_FRAMES    = 16,
    parameter int DURATION_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [sas_pkg::OPCODE_W-1:0]   opcode,
    input  logic [sas_pkg::ANIM_ID_W-1:0]  anim_id,
    input  logic [sas_pkg::SLOT_W-1:0]     frame_slot,
    input  logic [sas_pkg::FIELD_W-1:0]    frame_duration,
    input  logic [sas_pkg::SPRITE_W-1:0]   frame_sprite,
    input  logic [sas_pkg::TOTAL_W-1:0]    frame_total,
    input  logic                           loop_enable,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [sas_pkg::SPRITE_W-1:0]   sprite_out,
    output logic                           finished_out
);

    localparam int AIW     = (NUM_ANIMS > 1) ? $clog2(NUM_ANIMS) : 1;
    localparam int PW      = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CW      = $clog2(MAX_FRAMES + 1);
    localparam int DW      = DURATION_BITS;
    localparam int DEPTH   = NUM_ANIMS * MAX_FRAMES;
    localparam int FAW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FDW     = DW + sas_pkg::SPRITE_W;
    localparam int ADW     = CW + 1;

    // Request registers
    sas_pkg::op_t                  op_reg;
    logic [sas_pkg::ANIM_ID_W-1:0] id_reg;
    logic [sas_pkg::SLOT_W-1:0]    slot_reg;
    logic [sas_pkg::FIELD_W-1:0]   dur_reg;
    logic [sas_pkg::SPRITE_W-1:0]  spr_reg;
    logic [sas_pkg::TOTAL_W-1:0]   total_reg;
    logic                          loop_reg;

    // Play state
    sas_pkg::state_t state_reg, state_next;
    logic            playing_reg, playing_next;
    logic [AIW-1:0]  anim_reg, anim_next;
    logic [PW-1:0]   pos_reg, pos_next;
    logic [DW-1:0]   tick_reg, tick_next;
    logic            done_reg, done_next;
    logic [CW-1:0]   cur_cnt_reg, cur_cnt_next;
    logic            cur_loop_reg, cur_loop_next;

    // Result register
    logic                         out_valid_reg, out_valid_next;
    logic [sas_pkg::SPRITE_W-1:0] sprite_reg;
    logic                         finished_reg;
    logic                         out_load;

    // Memory and remainder unit hookup
    logic           frame_we;
    logic [FAW-1:0] frame_waddr;
    logic [FAW-1:0] frame_raddr;
    logic [FDW-1:0] frame_wdata;
    logic [FDW-1:0] frame_rdata;
    logic           anim_we;
    logic [ADW-1:0] anim_wdata;
    logic [ADW-1:0] anim_rdata;
    logic           mod_start;
    logic           mod_busy;
    logic [PW-1:0]  mod_rem;

    // Decode helpers
    logic [AIW-1:0] id_cast;
    logic           id_ok;
    logic           slot_ok;
    logic           same_anim;
    logic [CW-1:0]  total_sat;
    logic [DW-1:0]  fr_dur;
    logic [DW-1:0]  tick_inc;
    logic           pos_lt_cnt;
    logic           pos_at_end;
    logic [CW-1:0]  rd_cnt;
    logic           rd_loop;

    assign in_ready = (state_reg == sas_pkg::ST_IDLE);

    assign id_cast    = AIW'(id_reg);
    assign id_ok      = 32'(id_reg) < NUM_ANIMS;
    assign slot_ok    = 32'(slot_reg) < MAX_FRAMES;
    assign same_anim  = playing_reg && (anim_reg == id_cast);
    assign total_sat  = (32'(total_reg) > MAX_FRAMES) ? CW'(MAX_FRAMES) : CW'(total_reg);
    assign fr_dur     = frame_rdata[FDW-1:sas_pkg::SPRITE_W];
    assign tick_inc   = (tick_reg == {DW{1'b1}}) ? tick_reg : tick_reg + DW'(1);
    assign pos_lt_cnt = 32'(pos_reg) < 32'(cur_cnt_reg);
    assign pos_at_end = (32'(pos_reg) + 32'd1) >= 32'(cur_cnt_reg);
    assign rd_cnt     = anim_rdata[ADW-1:1];
    assign rd_loop    = anim_rdata[0];

    // Frame memory always reads the entry of the current frame
    assign frame_raddr = FAW'(anim_reg) * FAW'(MAX_FRAMES) + FAW'(pos_reg);
    assign frame_waddr = FAW'(id_cast) * FAW'(MAX_FRAMES) + FAW'(slot_reg);
    assign frame_wdata = {DW'(dur_reg), spr_reg};
    assign anim_wdata  = {total_sat, loop_reg};

    sas_frame_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (FAW),
        .DATA_W (FDW)
    ) u_frame_mem (
        .clk   (clk),
        .we    (frame_we),
        .waddr (frame_waddr),
        .wdata (frame_wdata),
        .raddr (frame_raddr),
        .rdata (frame_rdata)
    );

    sas_anim_tbl #(
        .DEPTH  (NUM_ANIMS),
        .ADDR_W (AIW),
        .DATA_W (ADW)
    ) u_anim_tbl (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (anim_we),
        .waddr (id_cast),
        .wdata (anim_wdata),
        .raddr (AIW'(anim_id)),
        .rdata (anim_rdata)
    );

    sas_mod_unit #(
        .DIVIDEND_W (PW),
        .DIVISOR_W  (CW)
    ) u_mod_unit (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (pos_reg),
        .divisor   (rd_cnt),
        .busy      (mod_busy),
        .remainder (mod_rem)
    );

    // Capture the request
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg    <= sas_pkg::op_t'(opcode);
            id_reg    <= anim_id;
            slot_reg  <= frame_slot;
            dur_reg   <= frame_duration;
            spr_reg   <= frame_sprite;
            total_reg <= frame_total;
            loop_reg  <= loop_enable;
        end
    end

    // Control and play state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sas_pkg::ST_IDLE;
            playing_reg   <= 1'b0;
            anim_reg      <= '0;
            pos_reg       <= '0;
            tick_reg      <= '0;
            done_reg      <= 1'b0;
            cur_cnt_reg   <= '0;
            cur_loop_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            playing_reg   <= playing_next;
            anim_reg      <= anim_next;
            pos_reg       <= pos_next;
            tick_reg      <= tick_next;
            done_reg      <= done_next;
            cur_cnt_reg   <= cur_cnt_next;
            cur_loop_reg  <= cur_loop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if (playing_reg && (cur_cnt_reg != '0) && pos_lt_cnt)
            begin
                sprite_reg <= frame_rdata[sas_pkg::SPRITE_W-1:0];
            end
            else
            begin
                sprite_reg <= '0;
            end
            finished_reg <= done_reg;
        end
    end

    // Next state and request execution
    always_comb
    begin
        state_next    = state_reg;
        playing_next  = playing_reg;
        anim_next     = anim_reg;
        pos_next      = pos_reg;
        tick_next     = tick_reg;
        done_next     = done_reg;
        cur_cnt_next  = cur_cnt_reg;
        cur_loop_next = cur_loop_reg;
        frame_we      = 1'b0;
        anim_we       = 1'b0;
        mod_start     = 1'b0;
        out_load      = 1'b0;

        unique case (state_reg)
            sas_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = sas_pkg::ST_EXEC;
                end
            end
            sas_pkg::ST_EXEC:
            begin
                state_next = sas_pkg::ST_LOOKUP;
                unique case (op_reg)
                    sas_pkg::OP_TICK:
                    begin
                        // Advance time on the running animation
                        if (playing_reg && !done_reg && (cur_cnt_reg != '0) && pos_lt_cnt)
                        begin
                            tick_next = tick_inc;
                            if (tick_inc >= fr_dur)
                            begin
                                tick_next = '0;
                                if (pos_at_end)
                                begin
                                    if (cur_loop_reg)
                                    begin
                                        pos_next = '0;
                                    end
                                    else
                                    begin
                                        pos_next  = PW'(cur_cnt_reg - CW'(1));
                                        done_next = 1'b1;
                                    end
                                end
                                else
                                begin
                                    pos_next = PW'(32'(pos_reg) + 32'd1);
                                end
                            end
                        end
                    end
                    sas_pkg::OP_PLAY,
                    sas_pkg::OP_PLAY_SYNCED:
                    begin
                        // Start a new animation unless it is already running
                        if (id_ok && !(same_anim && !done_reg))
                        begin
                            playing_next  = 1'b1;
                            anim_next     = id_cast;
                            done_next     = 1'b0;
                            cur_cnt_next  = rd_cnt;
                            cur_loop_next = rd_loop;
                            if ((op_reg == sas_pkg::OP_PLAY_SYNCED) && (rd_cnt != '0))
                            begin
                                mod_start  = 1'b1;
                                state_next = sas_pkg::ST_MOD;
                            end
                            else
                            begin
                                pos_next  = '0;
                                tick_next = '0;
                            end
                        end
                    end
                    sas_pkg::OP_WRITE_FRAME:
                    begin
                        frame_we = id_ok && slot_ok;
                    end
                    sas_pkg::OP_DEFINE_ANIM:
                    begin
                        // Update the descriptor and clamp the running position
                        if (id_ok)
                        begin
                            anim_we = 1'b1;
                            if (same_anim)
                            begin
                                cur_cnt_next  = total_sat;
                                cur_loop_next = loop_reg;
                                if (total_sat == '0)
                                begin
                                    pos_next  = '0;
                                    tick_next = '0;
                                end
                                else if (32'(pos_reg) >= 32'(total_sat))
                                begin
                                    pos_next = PW'(total_sat - CW'(1));
                                end
                            end
                        end
                    end
                    default:
                    begin
                        state_next = sas_pkg::ST_LOOKUP;
                    end
                endcase
            end
            sas_pkg::ST_MOD:
            begin
                // Hold until the remainder settles
                if (!mod_busy)
                begin
                    pos_next   = mod_rem;
                    state_next = sas_pkg::ST_LOOKUP;
                end
            end
            sas_pkg::ST_LOOKUP:
            begin
                state_next = sas_pkg::ST_RESP;
            end
            sas_pkg::ST_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = sas_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sas_pkg::ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign sprite_out   = sprite_reg;
    assign finished_out = finished_reg;

    // Finished only applies to an animation that is playing
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> playing_reg)
        else $error("finished set with nothing playing");

    // Between requests the frame position stays inside the animation
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sas_pkg::ST_IDLE) && playing_reg && (cur_cnt_reg != '0)
            |-> pos_lt_cnt)
        else $error("frame position beyond frame count");

    // The remainder unit runs only while the sequencer waits on it
    assert property (@(posedge clk) disable iff (!rst_n)
        mod_busy |-> (state_reg == sas_pkg::ST_MOD))
        else $error("remainder unit busy outside its wait state");

    // A new result appears only from the response state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == sas_pkg::ST_RESP))
        else $error("result loaded outside response state");

endmodule

// File: hdl/sas_frame_mem.sv
// Frame table memory: one write port, one registered read port.
module sas_frame_mem #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8,
    parameter int DATA_W = 32
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Write the addressed entry
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Register the read data
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/sas_anim_tbl.sv
// Animation descriptor memory with per-entry valid bits; unwritten entries read as zero.
module sas_anim_tbl #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4,
    parameter int DATA_W = 6
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]  valid_reg;
    logic [DATA_W-1:0] rdata_reg;
    logic              rvalid_reg;

    // Mark entries written since reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            rvalid_reg <= valid_reg[raddr];
        end
    end

    // Write data and register the read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rvalid_reg ? rdata_reg : '0;

endmodule

// File: hdl/sas_mod_unit.sv
// Iterative restoring remainder unit, one dividend bit per cycle.
module sas_mod_unit #(
    parameter int DIVIDEND_W = 4,
    parameter int DIVISOR_W  = 5
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  busy,
    output logic [DIVIDEND_W-1:0] remainder
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [CNT_W-1:0]      count_reg;
    logic [DIVIDEND_W-1:0] shift_reg;
    logic [DIVISOR_W-1:0]  divisor_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W:0]    trial;

    assign trial = {rem_reg, shift_reg[DIVIDEND_W-1]};

    // Step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (start)
        begin
            count_reg <= CNT_W'(DIVIDEND_W);
        end
        else if (count_reg != '0)
        begin
            count_reg <= count_reg - CNT_W'(1);
        end
    end

    // Shift in one dividend bit and subtract when it fits
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg     <= '0;
            shift_reg   <= dividend;
            divisor_reg <= divisor;
        end
        else if (count_reg != '0)
        begin
            shift_reg <= shift_reg << 1;
            if (trial >= {1'b0, divisor_reg})
            begin
                rem_reg <= DIVISOR_W'(trial - {1'b0, divisor_reg});
            end
            else
            begin
                rem_reg <= trial[DIVISOR_W-1:0];
            end
        end
    end

    assign busy      = (count_reg != '0);
    assign remainder = DIVIDEND_W'(rem_reg);

endmodule

// File: sim/sprite_animation_sequencer_core_tb.sv
// Self-checking testbench for the sprite animation sequencer core.
module sprite_animation_sequencer_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_ANIMS      = 16;
    localparam int MAX_FRAMES     = 16;
    localparam int DURATION_BITS  = 16;
    localparam int DUR_MAX        = (1 << DURATION_BITS) - 1;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int PHASE_ITEMS    = 200;
    localparam int NUM_PHASES     = 4;

    // Opcodes 5 to 7 have no function and must leave the state alone
    localparam logic [sas_pkg::OPCODE_W-1:0] OP_RESERVED_FIRST = 3'd5;
    localparam logic [sas_pkg::OPCODE_W-1:0] OP_RESERVED_LAST  = 3'd7;

    typedef struct {
        logic [sas_pkg::OPCODE_W-1:0]  opcode;
        logic [sas_pkg::ANIM_ID_W-1:0] anim_id;
        logic [sas_pkg::SLOT_W-1:0]    slot;
        logic [sas_pkg::FIELD_W-1:0]   duration;
        logic [sas_pkg::SPRITE_W-1:0]  sprite;
        logic [sas_pkg::TOTAL_W-1:0]   total;
        logic                          loop_en;
    } request_t;

    typedef struct {
        logic [sas_pkg::SPRITE_W-1:0] sprite;
        logic                         finished;
    } status_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic [sas_pkg::OPCODE_W-1:0]  opcode = '0;
    logic [sas_pkg::ANIM_ID_W-1:0] anim_id = '0;
    logic [sas_pkg::SLOT_W-1:0]    frame_slot = '0;
    logic [sas_pkg::FIELD_W-1:0]   frame_duration = '0;
    logic [sas_pkg::SPRITE_W-1:0]  frame_sprite = '0;
    logic [sas_pkg::TOTAL_W-1:0]   frame_total = '0;
    logic                          loop_enable = 1'b0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic [sas_pkg::SPRITE_W-1:0]  sprite_out;
    logic                          finished_out;

    request_t request_q[$];
    status_t  status_q[$];
    request_t drive_req;
    request_t seen_req;
    status_t  want;

    int  idle_pct = 0;
    int  stall_pct = 0;
    int  error_count = 0;
    int  quiet_cycles = 0;
    logic in_accepted = 1'b0;

    // Shadow of the sequencer state
    logic [sas_pkg::FIELD_W-1:0]  dur_tbl [NUM_ANIMS*MAX_FRAMES];
    logic [sas_pkg::SPRITE_W-1:0] spr_tbl [NUM_ANIMS*MAX_FRAMES];
    int   anim_len  [NUM_ANIMS];
    logic anim_wrap [NUM_ANIMS];
    logic now_playing = 1'b0;
    int   play_anim = 0;
    int   play_pos = 0;
    int   play_ticks = 0;
    logic play_done = 1'b0;

    // Frames written so far, used to keep every defined frame readable
    logic frame_written [NUM_ANIMS][MAX_FRAMES];

    sprite_animation_sequencer_core #(
        .NUM_ANIMS     (NUM_ANIMS),
        .MAX_FRAMES    (MAX_FRAMES),
        .DURATION_BITS (DURATION_BITS)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .anim_id        (anim_id),
        .frame_slot     (frame_slot),
        .frame_duration (frame_duration),
        .frame_sprite   (frame_sprite),
        .frame_total    (frame_total),
        .loop_enable    (loop_enable),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .sprite_out     (sprite_out),
        .finished_out   (finished_out)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Update the shadow state with one request and return the status it yields
    function automatic status_t apply_request(request_t r);
        int cnt;
        int entry;
        int total;
        status_t s;
        cnt = now_playing ? anim_len[play_anim] : 0;
        case (r.opcode)
            sas_pkg::OP_TICK:
            begin
                if (now_playing && !play_done && cnt > 0 && play_pos < cnt)
                begin
                    entry = play_anim * MAX_FRAMES + play_pos;
                    if (play_ticks < DUR_MAX)
                        play_ticks++;
                    if (play_ticks >= int'(dur_tbl[entry]))
                    begin
                        play_ticks = 0;
                        play_pos++;
                        if (play_pos >= cnt)
                        begin
                            if (anim_wrap[play_anim])
                                play_pos = 0;
                            else
                            begin
                                play_pos = cnt - 1;
                                play_done = 1'b1;
                            end
                        end
                    end
                end
            end
            sas_pkg::OP_PLAY, sas_pkg::OP_PLAY_SYNCED:
            begin
                if (!(now_playing && play_anim == int'(r.anim_id) && !play_done))
                begin
                    now_playing = 1'b1;
                    play_anim = int'(r.anim_id);
                    play_done = 1'b0;
                    if (r.opcode == sas_pkg::OP_PLAY)
                    begin
                        play_pos = 0;
                        play_ticks = 0;
                    end
                    else if (anim_len[r.anim_id] > 0)
                        play_pos = play_pos % anim_len[r.anim_id];
                    else
                    begin
                        play_pos = 0;
                        play_ticks = 0;
                    end
                end
            end
            sas_pkg::OP_WRITE_FRAME:
            begin
                entry = int'(r.anim_id) * MAX_FRAMES + int'(r.slot);
                dur_tbl[entry] = r.duration;
                spr_tbl[entry] = r.sprite;
            end
            sas_pkg::OP_DEFINE_ANIM:
            begin
                total = (r.total > MAX_FRAMES) ? MAX_FRAMES : int'(r.total);
                anim_len[r.anim_id] = total;
                anim_wrap[r.anim_id] = r.loop_en;
                if (now_playing && play_anim == int'(r.anim_id))
                begin
                    if (total == 0)
                    begin
                        play_pos = 0;
                        play_ticks = 0;
                    end
                    else if (play_pos >= total)
                        play_pos = total - 1;
                end
            end
            default: ;
        endcase
        cnt = now_playing ? anim_len[play_anim] : 0;
        if (cnt > 0 && play_pos < cnt)
            s.sprite = spr_tbl[play_anim * MAX_FRAMES + play_pos];
        else
            s.sprite = '0;
        s.finished = play_done;
        return s;
    endfunction

    // Count frames written without a gap from slot 0
    function automatic int written_prefix(int id);
        int n;
        n = 0;
        while (n < MAX_FRAMES && frame_written[id][n])
            n++;
        return n;
    endfunction

    task automatic queue_request(int op, int id, int slot,
                                 int dur, int spr, int total, int lp);
        request_t r;
        r.opcode   = sas_pkg::OPCODE_W'(op);
        r.anim_id  = sas_pkg::ANIM_ID_W'(id);
        r.slot     = sas_pkg::SLOT_W'(slot);
        r.duration = sas_pkg::FIELD_W'(dur);
        r.sprite   = sas_pkg::SPRITE_W'(spr);
        r.total    = sas_pkg::TOTAL_W'(total);
        r.loop_en  = 1'(lp);
        if (op == sas_pkg::OP_WRITE_FRAME)
            frame_written[id][slot] = 1'b1;
        request_q.push_back(r);
    endtask

    // Short durations mostly, so frames actually advance
    function automatic int pick_duration();
        int roll;
        roll = $urandom_range(99);
        if (roll < 75)
            return $urandom_range(4);
        else if (roll < 90)
            return $urandom_range(40, 5);
        else
            return $urandom_range(DUR_MAX);
    endfunction

    task automatic queue_random_request();
        int roll;
        int id;
        int prefix;
        int slot;
        int total;
        roll = $urandom_range(99);
        id = ($urandom_range(99) < 60) ? $urandom_range(3) : $urandom_range(NUM_ANIMS - 1);
        prefix = written_prefix(id);
        if (roll < 45)
            queue_request(sas_pkg::OP_TICK, id, $urandom, $urandom, $urandom, $urandom,
                          $urandom);
        else if (roll < 60)
            queue_request(sas_pkg::OP_PLAY, id, $urandom, $urandom, $urandom, $urandom,
                          $urandom);
        else if (roll < 70)
            queue_request(sas_pkg::OP_PLAY_SYNCED, id, $urandom, $urandom, $urandom,
                          $urandom, $urandom);
        else if (roll < 85)
        begin
            slot = (prefix < MAX_FRAMES && $urandom_range(99) < 70) ?
                   prefix : $urandom_range(MAX_FRAMES - 1);
            queue_request(sas_pkg::OP_WRITE_FRAME, id, slot, pick_duration(), $urandom,
                          $urandom, $urandom);
        end
        else if (roll < 98)
        begin
            // Define only over written frames; oversize counts only when full
            if (prefix == MAX_FRAMES && $urandom_range(99) < 30)
                total = $urandom_range(31, MAX_FRAMES + 1);
            else
                total = $urandom_range(prefix);
            queue_request(sas_pkg::OP_DEFINE_ANIM, id, $urandom, $urandom, $urandom, total,
                          $urandom);
        end
        else
            queue_request($urandom_range(OP_RESERVED_LAST, OP_RESERVED_FIRST), id, $urandom,
                          $urandom, $urandom, $urandom, $urandom);
    endtask

    // Hold the sender until every pending request has produced its result
    task automatic wait_drained();
        while (request_q.size() != 0 || (in_valid && !in_accepted) || status_q.size() != 0)
            @(posedge clk);
    endtask

    // Driver: present requests and randomize the result-side backpressure
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!(in_valid && !in_accepted))
            begin
                if (request_q.size() > 0 && $urandom_range(99) >= idle_pct)
                begin
                    drive_req = request_q.pop_front();
                    in_valid       <= 1'b1;
                    opcode         <= drive_req.opcode;
                    anim_id        <= drive_req.anim_id;
                    frame_slot     <= drive_req.slot;
                    frame_duration <= drive_req.duration;
                    frame_sprite   <= drive_req.sprite;
                    frame_total    <= drive_req.total;
                    loop_enable    <= drive_req.loop_en;
                end
                else
                    in_valid <= 1'b0;
            end
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Monitor: check results, predict accepted requests, watch for hangs
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (status_q.size() == 0)
                begin
                    $error("result with no request pending: sprite_out=%0h finished_out=%0b",
                           sprite_out, finished_out);
                    error_count++;
                end
                else
                begin
                    want = status_q.pop_front();
                    if (sprite_out !== want.sprite)
                    begin
                        $error("sprite_out: expected %0h, actual %0h", want.sprite, sprite_out);
                        error_count++;
                    end
                    if (finished_out !== want.finished)
                    begin
                        $error("finished_out: expected %0b, actual %0b", want.finished,
                               finished_out);
                        error_count++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                seen_req.opcode   = opcode;
                seen_req.anim_id  = anim_id;
                seen_req.slot     = frame_slot;
                seen_req.duration = frame_duration;
                seen_req.sprite   = frame_sprite;
                seen_req.total    = frame_total;
                seen_req.loop_en  = loop_enable;
                status_q.push_back(apply_request(seen_req));
            end
            in_accepted <= in_valid && in_ready;
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Stimulus: reset, directed sequence, then random phases with varied idling and stalling
    initial
    begin
        int idle_set  [NUM_PHASES];
        int stall_set [NUM_PHASES];
        idle_set  = '{0, 50, 0, 29};
        stall_set = '{0, 0, 50, 29};
        for (int a = 0; a < NUM_ANIMS; a++)
        begin
            anim_len[a] = 0;
            anim_wrap[a] = 1'b0;
            for (int f = 0; f < MAX_FRAMES; f++)
                frame_written[a][f] = 1'b0;
        end

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // Tick and play with nothing defined
        queue_request(sas_pkg::OP_TICK, 0, 0, 0, 0, 0, 0);
        queue_request(sas_pkg::OP_PLAY, 0, 0, 0, 0, 0, 0);
        // Three frames: zero, short and maximum duration
        queue_request(sas_pkg::OP_WRITE_FRAME, 1, 0, 0, 16'hFFFF, 0, 0);
        queue_request(sas_pkg::OP_WRITE_FRAME, 1, 1, 2, 16'h0001, 0, 0);
        queue_request(sas_pkg::OP_WRITE_FRAME, 1, 2, DUR_MAX, 16'h8000, 0, 0);
        queue_request(sas_pkg::OP_DEFINE_ANIM, 1, 0, 0, 0, 3, 0);
        queue_request(sas_pkg::OP_PLAY, 1, 0, 0, 0, 0, 0);
        repeat (4) queue_request(sas_pkg::OP_TICK, 0, 0, 0, 0, 0, 0);
        // Replay of the running animation changes nothing
        queue_request(sas_pkg::OP_PLAY, 1, 0, 0, 0, 0, 0);
        queue_request(sas_pkg::OP_PLAY_SYNCED, 1, 0, 0, 0, 0, 0);
        // Shrink while playing past the new end, then wrap
        queue_request(sas_pkg::OP_DEFINE_ANIM, 1, 0, 0, 0, 2, 1);
        queue_request(sas_pkg::OP_TICK, 0, 0, 0, 0, 0, 0);
        // Empty the playing animation
        queue_request(sas_pkg::OP_DEFINE_ANIM, 1, 0, 0, 0, 0, 0);
        queue_request(sas_pkg::OP_TICK, 0, 0, 0, 0, 0, 0);
        queue_request(sas_pkg::OP_WRITE_FRAME, 15, 15, 16'h5555, 16'hAAAA, 31, 1);
        // Reserved opcodes with all fields high
        for (int op = OP_RESERVED_FIRST; op <= OP_RESERVED_LAST; op++)
            queue_request(op, 15, 15, DUR_MAX, 16'hFFFF, 31, 1);
        // One-shot animation runs to its end, then restart and sync to empty
        queue_request(sas_pkg::OP_WRITE_FRAME, 2, 0, 1, 16'h1234, 0, 0);
        queue_request(sas_pkg::OP_DEFINE_ANIM, 2, 0, 0, 0, 1, 0);
        queue_request(sas_pkg::OP_PLAY, 2, 0, 0, 0, 0, 0);
        queue_request(sas_pkg::OP_TICK, 0, 0, 0, 0, 0, 0);
        queue_request(sas_pkg::OP_TICK, 0, 0, 0, 0, 0, 0);
        queue_request(sas_pkg::OP_PLAY, 2, 0, 0, 0, 0, 0);
        queue_request(sas_pkg::OP_PLAY_SYNCED, 1, 0, 0, 0, 0, 0);

        // Fill one animation completely so oversize counts can be defined
        for (int f = 0; f < MAX_FRAMES; f++)
            queue_request(sas_pkg::OP_WRITE_FRAME, 3, f, pick_duration(), $urandom,
                          $urandom, $urandom);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            idle_pct = idle_set[p];
            stall_pct = stall_set[p];
            for (int n = 0; n < PHASE_ITEMS; n++)
                queue_random_request();
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(negedge clk);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
